/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the console writer blocks. Every
// form samples on the rising edge of clock and is off while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge.
`define TCW_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define TCW_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/tcw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Item types, command codes, register indexes and character codes shared by
// the console writer modules.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // Video-memory command codes.
   typedef enum logic [2:0] {
      CMD_WRITE  = 3'd0,
      CMD_FILL   = 3'd1,
      CMD_COPY   = 3'd2,
      CMD_ORIGIN = 3'd3,
      CMD_CURSOR = 3'd4
   } cmd_type;

   // Input item.
   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_buffer;
   } req_type;

   // Result item.
   typedef struct packed {
      cmd_type     command;
      logic [15:0] dest_cell;
      logic [15:0] source_cell;
      logic [15:0] cell_count;
      logic [15:0] cell_value;
      logic        last_result;
   } rsp_type;

   // Configuration register indexes.
   localparam logic [2:0] CSR_NUM_COLUMNS    = 3'd0;
   localparam logic [2:0] CSR_NUM_LINES      = 3'd1;
   localparam logic [2:0] CSR_MEMORY_CELLS   = 3'd2;
   localparam logic [2:0] CSR_ERASE_CELL     = 3'd3;
   localparam logic [2:0] CSR_CHAR_ATTRIBUTE = 3'd4;
   localparam logic [2:0] CSR_SCROLL_TOP     = 3'd5;
   localparam logic [2:0] CSR_SCROLL_BOTTOM  = 3'd6;

   typedef struct packed {
      logic [7:0]  num_columns;
      logic [7:0]  num_lines;
      logic [15:0] memory_cells;
      logic [15:0] erase_cell;
      logic [7:0]  char_attribute;
      logic [7:0]  scroll_top;
      logic [7:0]  scroll_bottom;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      num_columns:    8'd80,
      num_lines:      8'd25,
      memory_cells:   16'd16384,
      erase_cell:     16'h0720,
      char_attribute: 8'h07,
      scroll_top:     8'd0,
      scroll_bottom:  8'd25
   };

   // Character codes.
   localparam logic [7:0] CHAR_LAST_CONTROL = 8'd31;
   localparam logic [7:0] CHAR_DELETE       = 8'd127;
   localparam logic [7:0] CHAR_LINE_FEED    = 8'd10;
   localparam logic [7:0] CHAR_VERT_TAB     = 8'd11;
   localparam logic [7:0] CHAR_FORM_FEED    = 8'd12;
   localparam logic [7:0] CHAR_CARRIAGE_RET = 8'd13;
   localparam logic [7:0] CHAR_BACKSPACE    = 8'd8;

   // Decoded operation passed from front to back.
   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_PRINT = 3'd1,
      OP_LF    = 3'd2,
      OP_CR    = 3'd3,
      OP_DEL   = 3'd4,
      OP_BS    = 3'd5
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  char_code;
      logic        end_of_buffer;
   } op_type;

endpackage

/* sv/tcw_fifo.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// tcw_fifo
// Small synchronous queue of register entries, used between front and back
// and as the result queue.
// ----------------------------------------------------------------------------
module tcw_fifo #(
   parameter type         item_type = logic,
   parameter int unsigned DEPTH     = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     empty
);

   localparam int unsigned PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CountWidth = $clog2(DEPTH + 1);

   item_type                entry_ff [DEPTH];
   logic [PtrWidth-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]   count_ff,  count_in;
   logic                    push_ok, pop_ok;

   assign full     = (count_ff == CountWidth'(DEPTH));
   assign empty    = (count_ff == '0);
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   `TCW_ASSERT(a_count_bound, count_ff <= CountWidth'(DEPTH), "fifo count above depth")
   `TCW_ASSERT_NEXT(a_count_grow, push_ok && !pop_ok,
                    count_ff == $past(count_ff) + 1'b1, "fifo count did not grow on push")
   `TCW_ASSERT_NEXT(a_count_shrink, pop_ok && !push_ok,
                    count_ff == $past(count_ff) - 1'b1, "fifo count did not shrink on pop")

endmodule

/* sv/tcw_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_front
// Accept character items and classify them into back-end operations.
// ----------------------------------------------------------------------------
module tcw_front (
   input  logic             req_push,
   input  tcw_pkg::req_type req_data,
   output logic             req_full,
   output logic             op_push,
   output tcw_pkg::op_type  op_item,
   input  logic             op_full
);

   tcw_pkg::op_kind_type kind;
   logic [7:0]           code;

   assign code = req_data.char_code;

   always_comb begin
      priority if (code > tcw_pkg::CHAR_LAST_CONTROL && code < tcw_pkg::CHAR_DELETE) begin
         kind = tcw_pkg::OP_PRINT;
      end else if (code == tcw_pkg::CHAR_LINE_FEED || code == tcw_pkg::CHAR_VERT_TAB ||
                   code == tcw_pkg::CHAR_FORM_FEED) begin
         kind = tcw_pkg::OP_LF;
      end else if (code == tcw_pkg::CHAR_CARRIAGE_RET) begin
         kind = tcw_pkg::OP_CR;
      end else if (code == tcw_pkg::CHAR_DELETE) begin
         kind = tcw_pkg::OP_DEL;
      end else if (code == tcw_pkg::CHAR_BACKSPACE) begin
         kind = tcw_pkg::OP_BS;
      end else begin
         kind = tcw_pkg::OP_NONE;
      end
   end

   // Drop ignored codes unless they close the buffer.
   assign req_full              = op_full;
   assign op_push               = req_push && !op_full &&
                                  (kind != tcw_pkg::OP_NONE || req_data.end_of_buffer);
   assign op_item.kind          = kind;
   assign op_item.char_code     = code;
   assign op_item.end_of_buffer = req_data.end_of_buffer;

endmodule

/* sv/tcw_back.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// tcw_back
// Cursor and window state plus the command sequencer; issues at most one
// command per cycle into the result queue, holding while that queue is full.
// ----------------------------------------------------------------------------
module tcw_back (
   input  logic             clock,
   input  logic             reset,
   input  tcw_pkg::cfg_type cfg,
   input  tcw_pkg::op_type  op_item,
   input  logic             op_empty,
   output logic             op_pop,
   output logic             rsp_push,
   output tcw_pkg::rsp_type rsp_item,
   input  logic             rsp_full
);

   typedef enum logic [7:0] {
      ST_HEAD    = 8'b0000_0001,
      ST_LF      = 8'b0000_0010,
      ST_WFILL   = 8'b0000_0100,
      ST_PFILL   = 8'b0000_1000,
      ST_ORG     = 8'b0001_0000,
      ST_WRITE   = 8'b0010_0000,
      ST_EOB_MUL = 8'b0100_0000,
      ST_EOB     = 8'b1000_0000
   } state_type;

   state_type   state_ff, state_in;
   logic [7:0]  col_ff, col_in;
   logic [7:0]  row_ff, row_in;
   logic [15:0] cell_ff, cell_in;
   logic [15:0] origin_ff, origin_in;
   logic [15:0] cur_prod_ff, cur_prod_in;

   // Products of the configuration, refreshed every cycle.
   logic [15:0] lines_cols_ff, body_ff, top_off_ff, region_cnt_ff, region_end_ff;
   logic [7:0]  region_rows;
   logic [8:0]  region_span;

   logic [15:0] cols16;
   logic [16:0] new_origin;
   logic [17:0] window_end;
   logic        wraps, full_screen, no_scroll, in_range, eob;
   logic        emit, advance, finish, after_lf, pop_req, lf_last;
   logic [15:0] part_dest;

   assign cols16      = 16'(cfg.num_columns);
   assign eob         = op_item.end_of_buffer;
   assign region_rows = (cfg.scroll_bottom > cfg.scroll_top) ?
                        cfg.scroll_bottom - cfg.scroll_top - 8'd1 : 8'd0;
   assign region_span = {1'b0, cfg.scroll_top} + {1'b0, region_rows};

   always_ff @(posedge clock) begin
      lines_cols_ff <= 16'(cfg.num_lines) * cols16;
      body_ff       <= (cfg.num_lines == 8'd0) ? 16'd0 :
                       16'(cfg.num_lines - 8'd1) * cols16;
      top_off_ff    <= 16'(cfg.scroll_top) * cols16;
      region_cnt_ff <= 16'(region_rows) * cols16;
      region_end_ff <= 16'(region_span) * cols16;
   end

   assign new_origin  = {1'b0, origin_ff} + 17'(cfg.num_columns);
   assign window_end  = {1'b0, new_origin} + 18'(lines_cols_ff);
   assign wraps       = window_end > 18'(cfg.memory_cells);
   assign full_screen = (cfg.scroll_top == 8'd0) && (cfg.scroll_bottom == cfg.num_lines);
   assign no_scroll   = ({1'b0, row_ff} + 9'd1) < {1'b0, cfg.scroll_bottom};
   assign in_range    = !(col_ff > cfg.num_columns || row_ff >= cfg.num_lines);
   assign part_dest   = origin_ff + top_off_ff;
   assign lf_last     = (op_item.kind != tcw_pkg::OP_PRINT) && !eob;

   always_comb begin
      state_in    = state_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      cell_in     = cell_ff;
      origin_in   = origin_ff;
      cur_prod_in = cur_prod_ff;
      emit        = 1'b0;
      finish      = 1'b0;
      after_lf    = 1'b0;
      pop_req     = 1'b0;
      rsp_item    = '0;
      unique case (state_ff)
         ST_HEAD: begin
            if (!op_empty) begin
               unique case (op_item.kind)
                  tcw_pkg::OP_PRINT: begin
                     if (col_ff >= cfg.num_columns) begin
                        // past the line end: back up a row, then feed
                        col_in   = col_ff - cfg.num_columns;
                        cell_in  = cell_ff - cols16;
                        state_in = ST_LF;
                     end else begin
                        emit                 = 1'b1;
                        rsp_item.command     = tcw_pkg::CMD_WRITE;
                        rsp_item.dest_cell   = cell_ff;
                        rsp_item.cell_value  = {cfg.char_attribute, op_item.char_code};
                        rsp_item.last_result = !eob;
                        cell_in              = cell_ff + 16'd1;
                        col_in               = col_ff + 8'd1;
                        finish               = 1'b1;
                     end
                  end
                  tcw_pkg::OP_LF: begin
                     state_in = ST_LF;
                  end
                  tcw_pkg::OP_CR: begin
                     cell_in = cell_ff - 16'(col_ff);
                     col_in  = 8'd0;
                     finish  = 1'b1;
                  end
                  tcw_pkg::OP_DEL: begin
                     if (col_ff != 8'd0) begin
                        emit                 = 1'b1;
                        rsp_item.command     = tcw_pkg::CMD_WRITE;
                        rsp_item.dest_cell   = cell_ff - 16'd1;
                        rsp_item.cell_value  = cfg.erase_cell;
                        rsp_item.last_result = !eob;
                        cell_in              = cell_ff - 16'd1;
                        col_in               = col_ff - 8'd1;
                     end
                     finish = 1'b1;
                  end
                  tcw_pkg::OP_BS: begin
                     if (col_ff != 8'd0) begin
                        cell_in = cell_ff - 16'd1;
                        col_in  = col_ff - 8'd1;
                     end
                     finish = 1'b1;
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end
         ST_LF: begin
            if (no_scroll) begin
               row_in   = row_ff + 8'd1;
               cell_in  = cell_ff + cols16;
               after_lf = 1'b1;
            end else if (full_screen && !wraps) begin
               // slide the window one row down through memory
               emit                = 1'b1;
               rsp_item.command    = tcw_pkg::CMD_FILL;
               rsp_item.dest_cell  = origin_ff + lines_cols_ff;
               rsp_item.cell_count = cols16;
               rsp_item.cell_value = cfg.erase_cell;
               origin_in           = new_origin[15:0];
               cell_in             = cell_ff + cols16;
               state_in            = ST_ORG;
            end else if (full_screen) begin
               // window runs off the end: copy it back to the base
               emit                 = 1'b1;
               rsp_item.command     = tcw_pkg::CMD_COPY;
               rsp_item.source_cell = new_origin[15:0];
               rsp_item.cell_count  = body_ff;
               cell_in              = cell_ff - origin_ff;
               origin_in            = 16'd0;
               state_in             = ST_WFILL;
            end else begin
               emit                 = 1'b1;
               rsp_item.command     = tcw_pkg::CMD_COPY;
               rsp_item.dest_cell   = part_dest;
               rsp_item.source_cell = part_dest + cols16;
               rsp_item.cell_count  = region_cnt_ff;
               state_in             = ST_PFILL;
            end
         end
         ST_WFILL: begin
            emit                = 1'b1;
            rsp_item.command    = tcw_pkg::CMD_FILL;
            rsp_item.dest_cell  = body_ff;
            rsp_item.cell_count = cols16;
            rsp_item.cell_value = cfg.erase_cell;
            state_in            = ST_ORG;
         end
         ST_PFILL: begin
            emit                 = 1'b1;
            rsp_item.command     = tcw_pkg::CMD_FILL;
            rsp_item.dest_cell   = origin_ff + region_end_ff;
            rsp_item.cell_count  = cols16;
            rsp_item.cell_value  = cfg.erase_cell;
            rsp_item.last_result = lf_last;
            after_lf             = 1'b1;
         end
         ST_ORG: begin
            emit                 = 1'b1;
            rsp_item.command     = tcw_pkg::CMD_ORIGIN;
            rsp_item.dest_cell   = origin_ff;
            rsp_item.last_result = lf_last;
            after_lf             = 1'b1;
         end
         ST_WRITE: begin
            emit                 = 1'b1;
            rsp_item.command     = tcw_pkg::CMD_WRITE;
            rsp_item.dest_cell   = cell_ff;
            rsp_item.cell_value  = {cfg.char_attribute, op_item.char_code};
            rsp_item.last_result = !eob;
            cell_in              = cell_ff + 16'd1;
            col_in               = col_ff + 8'd1;
            finish               = 1'b1;
         end
         ST_EOB_MUL: begin
            cur_prod_in = 16'(row_ff) * cols16;
            state_in    = ST_EOB;
         end
         ST_EOB: begin
            emit                 = 1'b1;
            rsp_item.command     = tcw_pkg::CMD_CURSOR;
            rsp_item.dest_cell   = in_range ? origin_ff + cur_prod_ff + 16'(col_ff) : cell_ff;
            rsp_item.last_result = 1'b1;
            cell_in              = rsp_item.dest_cell;
            pop_req              = 1'b1;
            state_in             = ST_HEAD;
         end
         default: begin
            state_in = ST_HEAD;
         end
      endcase
      if (after_lf) begin
         if (op_item.kind == tcw_pkg::OP_PRINT) begin
            state_in = ST_WRITE;
         end else begin
            finish = 1'b1;
         end
      end
      if (finish) begin
         if (eob) begin
            state_in = ST_EOB_MUL;
         end else begin
            pop_req  = 1'b1;
            state_in = ST_HEAD;
         end
      end
   end

   // Hold everything while a command waits for queue space.
   assign advance  = !emit || !rsp_full;
   assign rsp_push = emit && !rsp_full;
   assign op_pop   = pop_req && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_HEAD;
         col_ff    <= 8'd0;
         row_ff    <= 8'd0;
         cell_ff   <= 16'd0;
         origin_ff <= 16'd0;
      end else if (advance) begin
         state_ff  <= state_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         cell_ff   <= cell_in;
         origin_ff <= origin_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_prod_ff <= cur_prod_in;
   end

   `TCW_ASSERT(a_no_push_full, !(rsp_push && rsp_full), "command pushed into full queue")
   `TCW_ASSERT_IMP(a_pop_has_op, op_pop, !op_empty, "operation popped from empty queue")
   `TCW_ASSERT_IMP(a_cursor_last, rsp_push && state_ff == ST_EOB,
                   rsp_item.last_result && rsp_item.command == tcw_pkg::CMD_CURSOR,
                   "cursor command not marked last")

endmodule

/* sv/text_console_writer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console character writer: turns a character stream into
// video-memory commands (write cell, fill row, copy block, set origin,
// set cursor), keeping the cursor and the window origin.
// ----------------------------------------------------------------------------
//
//   port group  direction  handshake                 payload
//   req_        in         req_push / req_full       tcw_pkg::req_type
//   rsp_        out        rsp_pop / rsp_empty       tcw_pkg::rsp_type
//   csr_        in         csr_valid / csr_ready     csr_index, csr_wdata
//
// The back sequencer issues at most one command per cycle. A printable code
// writes its cell directly; a line feed enters its own state, then steps down a
// row or issues one scroll command at a time (two or three); a printable past
// the line end runs that line feed first and then writes. end_of_buffer adds a
// multiply step, then issues the cursor command. Items with no effect are dropped
// at the front. Reset is synchronous and clears cursor, window origin and queues
// at once; configuration returns to its defaults. A full result queue stalls the
// back sequencer only; the front keeps accepting until the operation queue fills.
// ----------------------------------------------------------------------------
module text_console_writer #(
   parameter int unsigned OP_DEPTH  = 4,
   parameter int unsigned RSP_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   // character items
   input  logic             req_push,
   input  tcw_pkg::req_type req_data,
   output logic             req_full,
   // command items
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output tcw_pkg::rsp_type rsp_data,
   // register writes
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [15:0]      csr_wdata
);

   tcw_pkg::cfg_type cfg_ff;
   tcw_pkg::op_type  front_item, back_item;
   tcw_pkg::rsp_type cmd_item;
   logic             op_push, op_full, op_pop, op_empty;
   logic             cmd_push, cmd_full;

   // Always writable; user must send writes only while block is idle; unchecked.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= tcw_pkg::CFG_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            tcw_pkg::CSR_NUM_COLUMNS:    cfg_ff.num_columns    <= csr_wdata[7:0];
            tcw_pkg::CSR_NUM_LINES:      cfg_ff.num_lines      <= csr_wdata[7:0];
            tcw_pkg::CSR_MEMORY_CELLS:   cfg_ff.memory_cells   <= csr_wdata;
            tcw_pkg::CSR_ERASE_CELL:     cfg_ff.erase_cell     <= csr_wdata;
            tcw_pkg::CSR_CHAR_ATTRIBUTE: cfg_ff.char_attribute <= csr_wdata[7:0];
            tcw_pkg::CSR_SCROLL_TOP:     cfg_ff.scroll_top     <= csr_wdata[7:0];
            tcw_pkg::CSR_SCROLL_BOTTOM:  cfg_ff.scroll_bottom  <= csr_wdata[7:0];
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   // Front: accept and classify characters.
   tcw_front u_front (
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .op_push  (op_push),
      .op_item  (front_item),
      .op_full  (op_full)
   );

   // Decoupling queue of decoded operations.
   tcw_fifo #(
      .item_type (tcw_pkg::op_type),
      .DEPTH     (OP_DEPTH)
   ) u_op_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_item (front_item),
      .full      (op_full),
      .pop       (op_pop),
      .pop_item  (back_item),
      .empty     (op_empty)
   );

   // Back: cursor/window state and command sequencing.
   tcw_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .op_item  (back_item),
      .op_empty (op_empty),
      .op_pop   (op_pop),
      .rsp_push (cmd_push),
      .rsp_item (cmd_item),
      .rsp_full (cmd_full)
   );

   // Result queue; its head drives the result ports.
   tcw_fifo #(
      .item_type (tcw_pkg::rsp_type),
      .DEPTH     (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_item (cmd_item),
      .full      (cmd_full),
      .pop       (rsp_pop),
      .pop_item  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the console character writer. A clocked driver
// pushes character items from a pending list, a clocked monitor pops command
// items, and a cycle-free model of the cursor and window state predicts each
// command, which is checked field by field in order. The run walks through
// several screen geometries: default, tiny screens with wrapping scrolls,
// partial and empty scroll regions, and the register extremes.
// ----------------------------------------------------------------------------
module tb_top;

   // -------------------------------------------------------------------------
   // Clock, reset and block ports
   // -------------------------------------------------------------------------
   logic             clock = 1'b0;
   logic             reset = 1'b1;

   logic             req_push = 1'b0;
   tcw_pkg::req_type req_data = '0;
   logic             req_full;

   logic             rsp_empty;
   logic             rsp_pop = 1'b0;
   tcw_pkg::rsp_type rsp_data;

   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [2:0]       csr_index = tcw_pkg::CSR_NUM_COLUMNS;
   logic [15:0]      csr_wdata = '0;

   always #4 clock = ~clock;

   text_console_writer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // Shared bench state
   // -------------------------------------------------------------------------
   tcw_pkg::req_type pending_chars[$];   // character items not yet offered
   tcw_pkg::rsp_type due_cmds[$];        // predicted commands, oldest first
   int               errors = 0;
   int               phase_id = 0;
   int               send_idle_pct = 0;  // chance per cycle that the sender holds off
   int               recv_idle_pct = 0;  // chance per cycle that the receiver holds off

   // Console model: geometry plus cursor and window position.
   tcw_pkg::cfg_type screen = tcw_pkg::CFG_RESET;
   logic [7:0]       col_pos = '0;
   logic [7:0]       row_pos = '0;
   logic [15:0]      cursor_offset = '0;
   logic [15:0]      origin_offset = '0;

   // -------------------------------------------------------------------------
   // Console model
   // -------------------------------------------------------------------------
   function automatic void add_cmd(tcw_pkg::cmd_type c, logic [31:0] dest,
                                   logic [31:0] src, logic [31:0] cnt,
                                   logic [31:0] val);
      tcw_pkg::rsp_type r;
      r.command     = c;
      r.dest_cell   = dest[15:0];
      r.source_cell = src[15:0];
      r.cell_count  = cnt[15:0];
      r.cell_value  = val[15:0];
      r.last_result = 1'b0;
      due_cmds.push_back(r);
   endfunction

   // Scroll the region up one row. A full-screen region moves the window
   // through memory; a partial region copies rows and blanks the last one.
   function automatic void scroll_region();
      logic [31:0] cols;
      logic [31:0] new_org;
      logic [31:0] win_end;
      logic [31:0] body;
      logic [31:0] dest;
      logic [31:0] rows;
      logic [31:0] cnt;
      cols = 32'(screen.num_columns);
      if (screen.scroll_top == 8'd0 && screen.scroll_bottom == screen.num_lines) begin
         new_org = 32'(origin_offset) + cols;
         win_end = new_org + 32'(screen.num_lines) * cols;
         cursor_offset = 16'(32'(cursor_offset) + cols);
         if (win_end <= 32'(screen.memory_cells)) begin
            origin_offset = new_org[15:0];
            add_cmd(tcw_pkg::CMD_FILL, win_end - cols, 32'd0, cols,
                    32'(screen.erase_cell));
         end else begin
            // window would run off the end of memory: pull it back to cell 0
            body = (screen.num_lines == 8'd0) ? 32'd0 :
                   (32'(screen.num_lines) - 32'd1) * cols;
            add_cmd(tcw_pkg::CMD_COPY, 32'd0, new_org, body, 32'd0);
            add_cmd(tcw_pkg::CMD_FILL, body, 32'd0, cols, 32'(screen.erase_cell));
            cursor_offset = cursor_offset - new_org[15:0];
            origin_offset = '0;
         end
         add_cmd(tcw_pkg::CMD_ORIGIN, 32'(origin_offset), 32'd0, 32'd0, 32'd0);
      end else begin
         dest = 32'(origin_offset) + cols * 32'(screen.scroll_top);
         // empty region: copy nothing but still blank the top row
         rows = (screen.scroll_bottom > screen.scroll_top) ?
                32'(screen.scroll_bottom) - 32'(screen.scroll_top) - 32'd1 : 32'd0;
         cnt  = rows * cols;
         add_cmd(tcw_pkg::CMD_COPY, dest, dest + cols, cnt, 32'd0);
         add_cmd(tcw_pkg::CMD_FILL, dest + cnt, 32'd0, cols, 32'(screen.erase_cell));
      end
   endfunction

   function automatic void line_feed();
      if (32'(row_pos) + 32'd1 < 32'(screen.scroll_bottom)) begin
         row_pos       = row_pos + 8'd1;
         cursor_offset = cursor_offset + 16'(screen.num_columns);
      end else begin
         scroll_region();
      end
   endfunction

   // Advance the model by one character item and queue the commands it causes.
   function automatic void interpret_char(tcw_pkg::req_type it);
      logic [7:0]       c;
      logic [31:0]      pos;
      int               first;
      tcw_pkg::rsp_type tail;
      c     = it.char_code;
      first = due_cmds.size();
      if (c > tcw_pkg::CHAR_LAST_CONTROL && c < tcw_pkg::CHAR_DELETE) begin
         if (col_pos >= screen.num_columns) begin
            // past the line end: step back onto the line, then wrap
            col_pos       = col_pos - screen.num_columns;
            cursor_offset = cursor_offset - 16'(screen.num_columns);
            line_feed();
         end
         add_cmd(tcw_pkg::CMD_WRITE, 32'(cursor_offset), 32'd0, 32'd0,
                 {16'd0, screen.char_attribute, c});
         cursor_offset = cursor_offset + 16'd1;
         col_pos       = col_pos + 8'd1;
      end else if (c == tcw_pkg::CHAR_LINE_FEED || c == tcw_pkg::CHAR_VERT_TAB ||
                   c == tcw_pkg::CHAR_FORM_FEED) begin
         line_feed();
      end else if (c == tcw_pkg::CHAR_CARRIAGE_RET) begin
         cursor_offset = cursor_offset - 16'(col_pos);
         col_pos       = '0;
      end else if (c == tcw_pkg::CHAR_DELETE) begin
         if (col_pos != 8'd0) begin
            cursor_offset = cursor_offset - 16'd1;
            col_pos       = col_pos - 8'd1;
            add_cmd(tcw_pkg::CMD_WRITE, 32'(cursor_offset), 32'd0, 32'd0,
                    32'(screen.erase_cell));
         end
      end else if (c == tcw_pkg::CHAR_BACKSPACE) begin
         if (col_pos != 8'd0) begin
            col_pos       = col_pos - 8'd1;
            cursor_offset = cursor_offset - 16'd1;
         end
      end

      if (it.end_of_buffer) begin
         // keep the old offset when the cursor sits off the screen
         if (!(col_pos > screen.num_columns || row_pos >= screen.num_lines)) begin
            pos = 32'(origin_offset) + 32'(row_pos) * 32'(screen.num_columns) +
                  32'(col_pos);
            cursor_offset = pos[15:0];
         end
         add_cmd(tcw_pkg::CMD_CURSOR, 32'(cursor_offset), 32'd0, 32'd0, 32'd0);
      end

      // flag the final command of this item
      if (due_cmds.size() > first) begin
         tail = due_cmds.pop_back();
         tail.last_result = 1'b1;
         due_cmds.push_back(tail);
      end
   endfunction

   function automatic void apply_setting(logic [2:0] idx, logic [15:0] val);
      case (idx)
         tcw_pkg::CSR_NUM_COLUMNS:    screen.num_columns    = val[7:0];
         tcw_pkg::CSR_NUM_LINES:      screen.num_lines      = val[7:0];
         tcw_pkg::CSR_MEMORY_CELLS:   screen.memory_cells   = val;
         tcw_pkg::CSR_ERASE_CELL:     screen.erase_cell     = val;
         tcw_pkg::CSR_CHAR_ATTRIBUTE: screen.char_attribute = val[7:0];
         tcw_pkg::CSR_SCROLL_TOP:     screen.scroll_top     = val[7:0];
         tcw_pkg::CSR_SCROLL_BOTTOM:  screen.scroll_bottom  = val[7:0];
         default: ;
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Checking
   // -------------------------------------------------------------------------
   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   function automatic void check_cmd(tcw_pkg::rsp_type got);
      tcw_pkg::rsp_type want;
      if (due_cmds.size() == 0) begin
         $display("%0t: command item with none expected, actual %p", $time, got);
         errors++;
         return;
      end
      want = due_cmds.pop_front();
      check_field("command",     16'(want.command),     16'(got.command));
      check_field("dest_cell",   want.dest_cell,        got.dest_cell);
      check_field("source_cell", want.source_cell,      got.source_cell);
      check_field("cell_count",  want.cell_count,       got.cell_count);
      check_field("cell_value",  want.cell_value,       got.cell_value);
      check_field("last_result", 16'(want.last_result), 16'(got.last_result));
   endfunction

   // -------------------------------------------------------------------------
   // Driver: offer pending character items, run the model on each accepted one
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : drive_chars
      logic             next_push;
      tcw_pkg::req_type next_data;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         next_push = req_push;
         next_data = req_data;
         if (req_push && !req_full) begin
            interpret_char(req_data);
            next_push = 1'b0;
         end
         // hold the item while full; otherwise load the next one unless idling
         if (!next_push && pending_chars.size() > 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            next_push = 1'b1;
            next_data = pending_chars.pop_front();
         end
         req_push <= next_push;
         req_data <= next_data;
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: pop command items and check them; one long hold-off in the
   // partial-region phase backs the block up until it refuses input
   // -------------------------------------------------------------------------
   int hold_left = 0;
   bit hold_done = 1'b0;

   always @(posedge clock) begin : take_cmds
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            check_cmd(rsp_data);
         end
         if (phase_id == 2 && !hold_done) begin
            hold_left = 80;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   function automatic void queue_char(logic [7:0] c, logic eob);
      tcw_pkg::req_type it;
      it.char_code     = c;
      it.end_of_buffer = eob;
      pending_chars.push_back(it);
   endfunction

   // Mostly text with line breaks and edits; some codes the block drops.
   // Only items with an effect count toward the wanted number.
   function automatic void queue_random(int want);
      tcw_pkg::req_type it;
      int               made;
      int               pick;
      made = 0;
      while (made < want) begin
         pick = $urandom_range(99);
         it.end_of_buffer = ($urandom_range(3) == 0);
         if (pick < 45) begin
            it.char_code = 8'($urandom_range(126, 32));
         end else if (pick < 65) begin
            case ($urandom_range(2))
               0:       it.char_code = tcw_pkg::CHAR_LINE_FEED;
               1:       it.char_code = tcw_pkg::CHAR_VERT_TAB;
               default: it.char_code = tcw_pkg::CHAR_FORM_FEED;
            endcase
         end else if (pick < 73) begin
            it.char_code = tcw_pkg::CHAR_CARRIAGE_RET;
         end else if (pick < 81) begin
            it.char_code = tcw_pkg::CHAR_DELETE;
         end else if (pick < 88) begin
            it.char_code = tcw_pkg::CHAR_BACKSPACE;
         end else begin
            case ($urandom_range(2))
               0:       it.char_code = 8'($urandom_range(7, 0));
               1:       it.char_code = 8'($urandom_range(31, 14));
               default: it.char_code = 8'($urandom_range(255, 128));
            endcase
         end
         if (pick < 88) begin
            made++;
         end
         pending_chars.push_back(it);
      end
   endfunction

   function automatic tcw_pkg::cfg_type random_screen();
      tcw_pkg::cfg_type s;
      s.num_columns    = ($urandom_range(1) == 1) ? 8'($urandom_range(8, 1)) :
                                                    8'($urandom_range(255, 1));
      s.num_lines      = ($urandom_range(1) == 1) ? 8'($urandom_range(6, 1)) :
                                                    8'($urandom_range(255, 1));
      s.memory_cells   = ($urandom_range(1) == 1) ? 16'($urandom_range(64, 1)) :
                                                    16'($urandom_range(32768, 1));
      s.erase_cell     = 16'($urandom_range(65535, 0));
      s.char_attribute = 8'($urandom_range(255, 0));
      if ($urandom_range(1) == 1) begin
         // full-screen region so that scrolls move the window
         s.scroll_top    = 8'd0;
         s.scroll_bottom = s.num_lines;
      end else begin
         s.scroll_top    = ($urandom_range(3) == 0) ? 8'($urandom_range(254, 0)) :
                                                      8'($urandom_range(4, 0));
         s.scroll_bottom = ($urandom_range(3) == 0) ? 8'($urandom_range(255, 1)) :
                                                      8'($urandom_range(6, 1));
      end
      return s;
   endfunction

   // Write every register in turn; keep valid high across back-to-back writes.
   task automatic write_screen(tcw_pkg::cfg_type s);
      logic [2:0]  order[7];
      logic [15:0] val;
      order = '{tcw_pkg::CSR_NUM_COLUMNS, tcw_pkg::CSR_NUM_LINES,
                tcw_pkg::CSR_MEMORY_CELLS, tcw_pkg::CSR_ERASE_CELL,
                tcw_pkg::CSR_CHAR_ATTRIBUTE, tcw_pkg::CSR_SCROLL_TOP,
                tcw_pkg::CSR_SCROLL_BOTTOM};
      @(posedge clock);
      for (int i = 0; i < 7; i++) begin
         case (order[i])
            tcw_pkg::CSR_NUM_COLUMNS:    val = 16'(s.num_columns);
            tcw_pkg::CSR_NUM_LINES:      val = 16'(s.num_lines);
            tcw_pkg::CSR_MEMORY_CELLS:   val = s.memory_cells;
            tcw_pkg::CSR_ERASE_CELL:     val = s.erase_cell;
            tcw_pkg::CSR_CHAR_ATTRIBUTE: val = 16'(s.char_attribute);
            tcw_pkg::CSR_SCROLL_TOP:     val = 16'(s.scroll_top);
            default:                     val = 16'(s.scroll_bottom);
         endcase
         csr_valid <= 1'b1;
         csr_index <= order[i];
         csr_wdata <= val;
         do @(posedge clock); while (!csr_ready);
         apply_setting(order[i], val);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic begin_phase(int id, int send_pct, int recv_pct);
      @(negedge clock);
      phase_id      = id;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // Wait until every item is in and every command is out, then
   // let the back end finish any item that leaves no command behind.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_chars.size() != 0 || req_push || due_cmds.size() != 0);
      repeat (30) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin : run_phases
      tcw_pkg::cfg_type s;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Default 80x25 screen: every code class, both printable ends, edits at
      // column zero, the three line-feed codes, dropped codes with and
      // without a cursor update.
      begin_phase(0, 30, 53);
      queue_char(8'd32, 1'b0);
      queue_char(8'd126, 1'b0);
      queue_char(tcw_pkg::CHAR_DELETE, 1'b0);
      queue_char(tcw_pkg::CHAR_BACKSPACE, 1'b0);
      queue_char(tcw_pkg::CHAR_CARRIAGE_RET, 1'b0);
      queue_char(tcw_pkg::CHAR_DELETE, 1'b0);
      queue_char(tcw_pkg::CHAR_BACKSPACE, 1'b0);
      queue_char(tcw_pkg::CHAR_LINE_FEED, 1'b0);
      queue_char(tcw_pkg::CHAR_VERT_TAB, 1'b0);
      queue_char(tcw_pkg::CHAR_FORM_FEED, 1'b0);
      queue_char(8'd0, 1'b1);
      queue_char(8'hff, 1'b0);
      queue_char(8'd9, 1'b0);
      queue_char(8'd128, 1'b0);
      queue_char("x", 1'b1);
      queue_random(8);
      wait_drained();

      // Tiny 4x3 screen in 20 cells: the cursor left over from the big screen
      // sits off screen and past the line end, and a few scrolls wrap the
      // window back to cell 0.
      s = '{num_columns: 8'd4, num_lines: 8'd3, memory_cells: 16'd20,
            erase_cell: 16'($urandom), char_attribute: 8'($urandom),
            scroll_top: 8'd0, scroll_bottom: 8'd3};
      write_screen(s);
      begin_phase(1, 30, 53);
      queue_char("!", 1'b1);
      queue_char(tcw_pkg::CHAR_CARRIAGE_RET, 1'b0);
      queue_char("a", 1'b0);
      queue_char("b", 1'b0);
      queue_char("c", 1'b0);
      queue_char("d", 1'b0);
      queue_char("e", 1'b0);
      queue_char(tcw_pkg::CHAR_LINE_FEED, 1'b0);
      queue_char(tcw_pkg::CHAR_LINE_FEED, 1'b0);
      queue_char(tcw_pkg::CHAR_LINE_FEED, 1'b1);
      queue_random(8);
      wait_drained();

      // Partial region, rows 1 to 3 of 6; the receiver stalls long here while
      // a run of printables backs both queues up.
      s = '{num_columns: 8'd5, num_lines: 8'd6, memory_cells: 16'd16384,
            erase_cell: 16'($urandom), char_attribute: 8'($urandom),
            scroll_top: 8'd1, scroll_bottom: 8'd4};
      write_screen(s);
      begin_phase(2, 30, 53);
      for (int i = 0; i < 10; i++) begin
         queue_char(8'("a" + i), 1'b0);
      end
      queue_random(8);
      wait_drained();

      // Upper extremes with an empty region: every line feed scrolls.
      s = '{num_columns: 8'd255, num_lines: 8'd255, memory_cells: 16'd32768,
            erase_cell: 16'hffff, char_attribute: 8'hff,
            scroll_top: 8'd254, scroll_bottom: 8'd1};
      write_screen(s);
      begin_phase(3, 53, 30);
      queue_random(8);
      wait_drained();

      // Lower extremes: one cell of memory, every scroll wraps.
      s = '{num_columns: 8'd1, num_lines: 8'd1, memory_cells: 16'd1,
            erase_cell: 16'h0000, char_attribute: 8'h00,
            scroll_top: 8'd0, scroll_bottom: 8'd1};
      write_screen(s);
      begin_phase(4, 53, 30);
      queue_random(8);
      wait_drained();

      // Wide two-line screen whose window outgrows memory on the first scroll.
      s = '{num_columns: 8'd255, num_lines: 8'd2, memory_cells: 16'd600,
            erase_cell: 16'($urandom), char_attribute: 8'($urandom),
            scroll_top: 8'd0, scroll_bottom: 8'd2};
      write_screen(s);
      begin_phase(5, 53, 30);
      queue_random(8);
      wait_drained();

      // Random geometries with no idling on either side.
      for (int p = 6; p < 8; p++) begin
         write_screen(random_screen());
         begin_phase(p, 0, 0);
         queue_random(8);
         wait_drained();
      end

      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Hard stop far beyond the slowest correct run.
   initial begin : watchdog
      #1_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
